// ----- src/lpl_pkg.sv -----
`timescale 1ns / 1ps
// shared types, widths and constants of the lookahead peak limiter
package lpl_pkg;

   localparam int LPL_MAX_DELAY_DEFAULT = 1024;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int SAMPLE_W = 16;
   localparam int COEFF_W  = 16;
   localparam int THR_W    = 15;
   localparam int MAKEUP_W = 16;
   localparam int DLEN_W   = 11;
   localparam int PEAK_W   = 32;
   localparam int GAIN_W   = 17;

   localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'h10000;

   localparam logic [COEFF_W-1:0]  ATTACK_RESET    = 16'd6554;
   localparam logic [COEFF_W-1:0]  RELEASE_RESET   = 16'd66;
   localparam logic [THR_W-1:0]    THRESHOLD_RESET = 15'd29491;
   localparam logic [MAKEUP_W-1:0] MAKEUP_RESET    = 16'd4096;
   localparam logic [DLEN_W-1:0]   DLEN_RESET      = 11'd48;

   // serial multiplier: signed multiplicand, unsigned multiplier, one bit a cycle
   localparam int MUL_MC_W   = 34;
   localparam int MUL_MR_W   = 17;
   localparam int MUL_PROD_W = MUL_MC_W + MUL_MR_W;
   localparam int MUL_CNT_W  = 5;

   // serial divider: one quotient bit a cycle
   localparam int DIV_Q_W   = 17;
   localparam int DIV_CNT_W = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATTACK    = 3'd0,
      CSR_RELEASE   = 3'd1,
      CSR_THRESHOLD = 3'd2,
      CSR_MAKEUP    = 3'd3,
      CSR_DELAY     = 3'd4
   } lpl_csr_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_PEAK,
      ST_DIV,
      ST_GAIN,
      ST_SCALE,
      ST_MAKEUP,
      ST_DONE
   } lpl_state_type;

endpackage

// ----- src/lookahead_peak_limiter.sv -----
`timescale 1ns / 1ps
// lookahead peak limiter top level: control sequence, delay ring and registers
// each sample runs through five serial passes in order (peak multiply, gain divide,
//   gain multiply, two output multiplies); a new sample is taken only once the
//   result word of the last one has been handed to rsp_
// reset: synchronous; then a pass over all MAX_DELAY entries zeroes the delay ring while
//   req_tready stays low; csr writes are taken throughout
module lookahead_peak_limiter #(
   parameter int MAX_DELAY = lpl_pkg::LPL_MAX_DELAY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lpl_pkg::REQ_TDATA_W-1:0]   req_tdata,   // sample_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lpl_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // sample_out, gain_now, zero pad
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lpl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lpl_pkg::CSR_DATA_W-1:0]    csr_data
);
   import lpl_pkg::*;

   localparam int PW = $clog2(MAX_DELAY);
   localparam int LW = PW + 1;
   localparam int PAD_W = RSP_TDATA_W - SAMPLE_W - GAIN_W;

   lpl_state_type state_ff, state_in;

   logic [PW-1:0]       clr_ff, clr_in;
   logic [PW-1:0]       wp_ff, wp_in;
   logic [PW-1:0]       rp_ff, rp_in;
   logic [COEFF_W-1:0]  attack_ff, attack_in;
   logic [COEFF_W-1:0]  release_ff, release_in;
   logic [THR_W-1:0]    threshold_ff, threshold_in;
   logic [MAKEUP_W-1:0] makeup_ff, makeup_in;
   logic [DLEN_W-1:0]   dlen_ff, dlen_in;
   logic [PEAK_W-1:0]   peak_ff, peak_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [SAMPLE_W-1:0] res_ff, res_in;
   logic [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic [GAIN_W-1:0]   out_gain_ff, out_gain_in;
   logic [SAMPLE_W-1:0] rd_data_ff;

   logic [SAMPLE_W-1:0] mem [MAX_DELAY];
   logic                mem_we;
   logic [PW-1:0]       mem_waddr;
   logic [SAMPLE_W-1:0] mem_wdata;
   logic                rd_en;

   logic                  mul_start;
   logic [MUL_MC_W-1:0]   mul_mc;
   logic [MUL_MR_W-1:0]   mul_mr;
   logic                  mul_done;
   logic [MUL_PROD_W-1:0] mul_prod;
   logic                  div_start;
   logic [PEAK_W-1:0]     div_divisor;
   logic                  div_done;
   logic [GAIN_W-1:0]     div_quot;

   logic [SAMPLE_W-1:0] mag;
   logic [PEAK_W-1:0]   mag_q;
   logic [PEAK_W:0]     peak_diff;
   logic [COEFF_W-1:0]  peak_c;
   logic [PEAK_W-1:0]   peak_new;
   logic [GAIN_W:0]     gain_diff;
   logic [COEFF_W-1:0]  gain_c;
   logic [GAIN_W-1:0]   gain_new;
   logic [SAMPLE_W-1:0] dmag;
   logic [18:0]         scaled;
   logic [SAMPLE_W-1:0] sat;
   logic [LW-1:0]       eff_len;
   logic [LW-1:0]       wp_next;
   logic [LW-1:0]       rp_next;
   logic                out_free;

   lpl_smul u_lpl_smul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .mc    (mul_mc),
      .mr    (mul_mr),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   lpl_sdiv u_lpl_sdiv (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .thr     (threshold_ff),
      .divisor (div_divisor),
      .done    (div_done),
      .quot    (div_quot)
   );

   // datapath around the serial units
   always_comb begin
      mag       = sample_ff[SAMPLE_W-1] ? SAMPLE_W'(16'd0 - sample_ff) : sample_ff;
      mag_q     = {mag, 16'h0000};
      peak_c    = (mag_q > peak_ff) ? attack_ff : release_ff;
      peak_diff = {1'b0, mag_q} - {1'b0, peak_ff};
      peak_new  = peak_ff + mul_prod[47:16];
      gain_c    = (div_quot < gain_ff) ? attack_ff : release_ff;
      gain_diff = {1'b0, div_quot} - {1'b0, gain_ff};
      gain_new  = gain_ff + mul_prod[32:16];
      dmag      = rd_data_ff[SAMPLE_W-1] ? SAMPLE_W'(16'd0 - rd_data_ff) : rd_data_ff;
      scaled    = mul_prod[46:28];
      if (rd_data_ff[SAMPLE_W-1]) begin
         sat = (scaled > 19'd32768) ? 16'h8000 : SAMPLE_W'(19'd0 - scaled);
      end else begin
         sat = (scaled > 19'd32767) ? 16'h7fff : scaled[SAMPLE_W-1:0];
      end
   end

   // ring length in use and pointer wrap
   always_comb begin
      if (dlen_ff == '0) begin
         eff_len = LW'(1);
      end else if (32'(dlen_ff) > 32'(MAX_DELAY)) begin
         eff_len = LW'(MAX_DELAY);
      end else begin
         eff_len = LW'(dlen_ff);
      end
      wp_next = {1'b0, wp_ff} + LW'(1);
      rp_next = {1'b0, rp_ff} + LW'(1);
   end

   // configuration writes
   always_comb begin
      attack_in    = attack_ff;
      release_in   = release_ff;
      threshold_in = threshold_ff;
      makeup_in    = makeup_ff;
      dlen_in      = dlen_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ATTACK:    attack_in    = csr_data;
            CSR_RELEASE:   release_in   = csr_data;
            CSR_THRESHOLD: threshold_in = csr_data[THR_W-1:0];
            CSR_MAKEUP:    makeup_in    = csr_data;
            CSR_DELAY:     dlen_in      = csr_data[DLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      out_free      = !rsp_valid_ff || rsp_tready;
      state_in      = state_ff;
      clr_in        = clr_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      peak_in       = peak_ff;
      gain_in       = gain_ff;
      sample_in     = sample_ff;
      res_in        = res_ff;
      out_sample_in = out_sample_ff;
      out_gain_in   = out_gain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      mem_we        = 1'b0;
      mem_waddr     = wp_ff;
      mem_wdata     = req_tdata;
      rd_en         = 1'b0;
      mul_start     = 1'b0;
      mul_mc        = '0;
      mul_mr        = '0;
      div_start     = 1'b0;
      div_divisor   = peak_new;
      req_tready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            if (clr_ff == PW'(MAX_DELAY - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mem_we    = 1'b1;
               sample_in = req_tdata;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            rd_en     = 1'b1;
            mul_start = 1'b1;
            mul_mc    = {peak_diff[PEAK_W], peak_diff};
            mul_mr    = {1'b0, peak_c};
            state_in  = ST_PEAK;
         end
         ST_PEAK: begin
            if (mul_done) begin
               peak_in   = peak_new;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               mul_start = 1'b1;
               mul_mc    = {{(MUL_MC_W-GAIN_W-1){gain_diff[GAIN_W]}}, gain_diff};
               mul_mr    = {1'b0, gain_c};
               state_in  = ST_GAIN;
            end
         end
         ST_GAIN: begin
            if (mul_done) begin
               gain_in   = gain_new;
               mul_start = 1'b1;
               mul_mc    = {{(MUL_MC_W-SAMPLE_W){1'b0}}, dmag};
               mul_mr    = gain_new;
               state_in  = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_mc    = {2'b00, mul_prod[31:0]};
               mul_mr    = {1'b0, makeup_ff};
               state_in  = ST_MAKEUP;
            end
         end
         ST_MAKEUP: begin
            if (mul_done) begin
               res_in   = sat;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_sample_in = res_ff;
               out_gain_in   = gain_ff;
               wp_in         = (wp_next >= eff_len) ? '0 : wp_next[PW-1:0];
               rp_in         = (rp_next >= eff_len) ? '0 : rp_next[PW-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         rp_ff        <= PW'(1);
         attack_ff    <= ATTACK_RESET;
         release_ff   <= RELEASE_RESET;
         threshold_ff <= THRESHOLD_RESET;
         makeup_ff    <= MAKEUP_RESET;
         dlen_ff      <= DLEN_RESET;
         peak_ff      <= '0;
         gain_ff      <= UNITY_GAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         attack_ff    <= attack_in;
         release_ff   <= release_in;
         threshold_ff <= threshold_in;
         makeup_ff    <= makeup_in;
         dlen_ff      <= dlen_in;
         peak_ff      <= peak_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      res_ff        <= res_in;
      out_sample_ff <= out_sample_in;
      out_gain_ff   <= out_gain_in;
   end

   // delay ring
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rp_ff];
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_gain_ff, out_sample_ff};

endmodule

// ----- src/lpl_smul.sv -----
`timescale 1ns / 1ps
// shift-add multiplier, one multiplier bit per cycle, full signed product
module lpl_smul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lpl_pkg::MUL_MC_W-1:0]      mc,
   input  logic [lpl_pkg::MUL_MR_W-1:0]      mr,
   output logic                              done,
   output logic [lpl_pkg::MUL_PROD_W-1:0]    prod
);
   import lpl_pkg::*;

   logic [MUL_MC_W-1:0]  mc_ff, mc_in;
   logic [MUL_MC_W-1:0]  hi_ff, hi_in;
   logic [MUL_MR_W-1:0]  lo_ff, lo_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_MC_W:0]    addend;
   logic [MUL_MC_W:0]    sum;

   always_comb begin
      addend  = lo_ff[0] ? {mc_ff[MUL_MC_W-1], mc_ff} : '0;
      sum     = {hi_ff[MUL_MC_W-1], hi_ff} + addend;
      mc_in   = mc_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         mc_in   = mc;
         hi_in   = '0;
         lo_in   = mr;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[MUL_MC_W:1];
         lo_in  = {sum[0], lo_ff[MUL_MR_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_MR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mc_ff <= mc_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};

endmodule

// ----- src/lpl_sdiv.sv -----
`timescale 1ns / 1ps
// restoring divider for threshold/peak, one quotient bit per cycle, clamped to unity
module lpl_sdiv (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lpl_pkg::THR_W-1:0]     thr,
   input  logic [lpl_pkg::PEAK_W-1:0]    divisor,
   output logic                          done,
   output logic [lpl_pkg::GAIN_W-1:0]    quot
);
   import lpl_pkg::*;

   localparam int SHIFT_W = PEAK_W - DIV_Q_W;
   localparam int TOP_W   = PEAK_W - THR_W - SHIFT_W;

   logic [PEAK_W-1:0]    r_ff, r_in;
   logic [PEAK_W-1:0]    d_ff, d_in;
   logic [DIV_Q_W-1:0]   q_ff, q_in;
   logic                 ovf_ff, ovf_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [PEAK_W-1:0]    r_init;
   logic [PEAK_W:0]      r2;
   logic [PEAK_W:0]      r2_sub;
   logic                 ge;

   always_comb begin
      // threshold << 32 with the low quotient-width bits still to be shifted in
      r_init  = {{TOP_W{1'b0}}, thr, {SHIFT_W{1'b0}}};
      r2      = {r_ff, 1'b0};
      r2_sub  = r2 - {1'b0, d_ff};
      ge      = r2 >= {1'b0, d_ff};
      r_in    = r_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // quotient of 2^17 or more saturates; a zero peak lands here too
         r_in    = r_init;
         d_in    = divisor;
         q_in    = '0;
         ovf_in  = r_init >= divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = ge ? r2_sub[PEAK_W-1:0] : r2[PEAK_W-1:0];
         q_in   = {q_ff[DIV_Q_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign quot = (ovf_ff || (q_ff > UNITY_GAIN)) ? UNITY_GAIN : q_ff;

endmodule

// ----- src/lpl_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the lookahead peak limiter, bound to the top level
module lpl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lpl_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import lpl_pkg::*;

   // reset empties the block and starts the ring clear
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("ready or valid high right after reset");

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed while stalled");

   // gain never above unity, pad bits zero
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[32:16] <= UNITY_GAIN) && (rsp_tdata[39:33] == 7'd0))
      else $error("gain above unity or nonzero pad");

   // zero gain mutes the output
   a_zero_gain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[32:16] == 17'd0) |-> rsp_tdata[15:0] == 16'd0)
      else $error("nonzero sample with zero gain");

   // one sample in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second sample taken while busy");

endmodule

bind lookahead_peak_limiter lpl_checker u_lpl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// testbench for lookahead_peak_limiter: directed and random sample streams checked word by word
module tb;
   import lpl_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int IDLE_PCT     = 29;
   localparam int RING_DEPTH   = LPL_MAX_DELAY_DEFAULT;
   localparam int DRAIN_CYCLES = 120;
   localparam int PRINT_MAX    = 40;
   localparam int PHASE_ITEMS  = 205;
   localparam int EDGE_ITEMS   = 40;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_out;
      logic [GAIN_W-1:0]   gain_now;
   } limited_word_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // sample_in
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // sample_out, gain_now, zero pad
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   logic req_taken;
   bit   calm;
   int   err_cnt;
   int   cycle_cnt;

   logic [SAMPLE_W-1:0] sample_q[$];
   limited_word_type    limited_q[$];

   // predictor copy of registers and state
   bit [COEFF_W-1:0]  cfg_attack;
   bit [COEFF_W-1:0]  cfg_release;
   bit [THR_W-1:0]    cfg_threshold;
   bit [MAKEUP_W-1:0] cfg_makeup;
   bit [DLEN_W-1:0]   cfg_delay;
   bit [PEAK_W-1:0]   env_peak;
   bit [GAIN_W-1:0]   gain_smooth;
   bit [SAMPLE_W-1:0] ring [RING_DEPTH];
   int unsigned       wr_ptr;
   int unsigned       rd_ptr;

   logic [SAMPLE_W-1:0] corner_samples [20] = '{
      16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
      16'h7FFF, 16'h0000, 16'h4000, 16'hC000, 16'h5555, 16'hAAAA, 16'h0100, 16'hFF00,
      16'h8001, 16'h7FFE, 16'h0000, 16'h0000
   };

   lookahead_peak_limiter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic reset_limiter_model;
      cfg_attack    = ATTACK_RESET;
      cfg_release   = RELEASE_RESET;
      cfg_threshold = THRESHOLD_RESET;
      cfg_makeup    = MAKEUP_RESET;
      cfg_delay     = DLEN_RESET;
      env_peak      = '0;
      gain_smooth   = UNITY_GAIN;
      foreach (ring[i]) ring[i] = '0;
      wr_ptr = 0;
      rd_ptr = 1;
   endtask

   function automatic limited_word_type limit_sample(input logic [SAMPLE_W-1:0] raw);
      bit [63:0] unity, mag_q, coeff, target, quot, len, d, dmag, prod;
      limited_word_type w;
      unity = 64'(UNITY_GAIN);
      mag_q = (raw[SAMPLE_W-1] ? (unity - 64'(raw)) : 64'(raw)) << 16;
      coeff = (mag_q > 64'(env_peak)) ? 64'(cfg_attack) : 64'(cfg_release);
      env_peak = PEAK_W'(((unity - coeff) * 64'(env_peak) + coeff * mag_q) >> 16);
      if (env_peak == 0) begin
         target = unity;
      end else begin
         quot = (64'(cfg_threshold) << 32) / 64'(env_peak);
         target = (quot > unity) ? unity : quot;
      end
      coeff = (target < 64'(gain_smooth)) ? 64'(cfg_attack) : 64'(cfg_release);
      gain_smooth = GAIN_W'(((unity - coeff) * 64'(gain_smooth) + coeff * target) >> 16);
      ring[wr_ptr] = raw;
      d = 64'(ring[rd_ptr]);
      dmag = d[SAMPLE_W-1] ? (unity - d) : d;
      prod = (dmag * 64'(gain_smooth) * 64'(cfg_makeup)) >> 28;
      if (d[SAMPLE_W-1]) begin
         w.sample_out = (prod > 64'd32768) ? 16'h8000 : SAMPLE_W'(64'd0 - prod);
      end else begin
         w.sample_out = (prod > 64'd32767) ? 16'h7FFF : prod[SAMPLE_W-1:0];
      end
      w.gain_now = gain_smooth;
      if (cfg_delay == 0) begin
         len = 64'(1);
      end else if (cfg_delay > RING_DEPTH) begin
         len = 64'(RING_DEPTH);
      end else begin
         len = 64'(cfg_delay);
      end
      rd_ptr = (64'(rd_ptr) + 1 >= len) ? 0 : rd_ptr + 1;
      wr_ptr = (64'(wr_ptr) + 1 >= len) ? 0 : wr_ptr + 1;
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (err_cnt < PRINT_MAX) begin
         $display("tb: %s mismatch at cycle %0d: got %0h want %0h", what, cycle_cnt, got, want);
      end
      err_cnt++;
   endtask

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // predictor and checker
   always @(posedge clock) begin : monitor
      limited_word_type want;
      req_taken <= !reset && req_tvalid && req_tready;
      if (reset) begin
         reset_limiter_model();
      end else begin
         if (req_tvalid && req_tready) begin
            limited_q.push_back(limit_sample(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (limited_q.size() == 0) begin
               report_mismatch("unexpected word", 64'(rsp_tdata), 64'd0);
            end else begin
               want = limited_q.pop_front();
               if (rsp_tdata[SAMPLE_W-1:0] !== want.sample_out) begin
                  report_mismatch("sample_out", 64'(rsp_tdata[SAMPLE_W-1:0]),
                                  64'(want.sample_out));
               end
               if (rsp_tdata[SAMPLE_W +: GAIN_W] !== want.gain_now) begin
                  report_mismatch("gain_now", 64'(rsp_tdata[SAMPLE_W +: GAIN_W]),
                                  64'(want.gain_now));
               end
               if (rsp_tdata[RSP_TDATA_W-1:SAMPLE_W+GAIN_W] !== '0) begin
                  report_mismatch("pad bits", 64'(rsp_tdata[RSP_TDATA_W-1:SAMPLE_W+GAIN_W]),
                                  64'd0);
               end
            end
         end
      end
   end

   // sample driver and result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (sample_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= sample_q.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_ATTACK:    cfg_attack    = value;
         CSR_RELEASE:   cfg_release   = value;
         CSR_THRESHOLD: cfg_threshold = value[THR_W-1:0];
         CSR_MAKEUP:    cfg_makeup    = value;
         CSR_DELAY:     cfg_delay     = value[DLEN_W-1:0];
         default:       ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_results;
      while (sample_q.size() != 0 || req_tvalid || limited_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_coeff;
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         default: return CSR_DATA_W'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_delay;
      case ($urandom_range(9))
         0:       return '0;
         1:       return CSR_DATA_W'(1);
         2:       return CSR_DATA_W'(RING_DEPTH);
         3:       return CSR_DATA_W'($urandom_range(65535));
         default: return CSR_DATA_W'($urandom_range(64, 2));
      endcase
   endfunction

   function automatic int pick_level;
      case ($urandom_range(3))
         0:       return 32768;
         1:       return $urandom_range(32768, 20000);
         2:       return $urandom_range(2000);
         default: return $urandom_range(32768);
      endcase
   endfunction

   // bursts at a held level with occasional wideband words
   task automatic run_bursts(input int n);
      int level, left;
      logic [SAMPLE_W:0] m;
      level = 0;
      left = 0;
      for (int i = 0; i < n; i++) begin
         if (left == 0) begin
            left = $urandom_range(48, 8);
            level = pick_level();
         end
         left--;
         if ($urandom_range(99) < 85) begin
            m = (SAMPLE_W + 1)'($urandom_range(level));
         end else begin
            m = (SAMPLE_W + 1)'($urandom_range(32768));
         end
         if ($urandom_range(1) != 0) begin
            sample_q.push_back(SAMPLE_W'((SAMPLE_W + 1)'(UNITY_GAIN) - m));
         end else begin
            sample_q.push_back(m[SAMPLE_W-1:0]);
         end
      end
      drain_results();
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] atk, input logic [CSR_DATA_W-1:0] rel,
                                input logic [CSR_DATA_W-1:0] thr, input logic [CSR_DATA_W-1:0] mk,
                                input logic [CSR_DATA_W-1:0] dly);
      write_reg(CSR_ATTACK, atk);
      write_reg(CSR_RELEASE, rel);
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_MAKEUP, mk);
      write_reg(CSR_DELAY, dly);
   endtask

   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      calm       = 1'b0;
      err_cnt    = 0;
      cycle_cnt  = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset register values
      foreach (corner_samples[i]) sample_q.push_back(corner_samples[i]);
      drain_results();

      // unused register indexes must leave the settings alone
      for (int i = int'(CSR_DELAY) + 1; i < 2 ** CSR_IDX_W; i++) begin
         write_reg(CSR_IDX_W'(i), CSR_DATA_W'($urandom_range(65535)));
      end

      // extremes, threshold and length masked to width
      apply_setting('1, '0, 16'h8000, '1, 16'd1);
      run_bursts(EDGE_ITEMS);
      apply_setting('0, '1, 16'h7FFF, '0, '0);
      run_bursts(EDGE_ITEMS);
      apply_setting('1, '1, '1, MAKEUP_RESET, 16'h07FF);
      run_bursts(EDGE_ITEMS);

      for (int p = 0; p < 8; p++) begin
         apply_setting(pick_coeff(), pick_coeff(), CSR_DATA_W'($urandom_range(65535)),
                       CSR_DATA_W'($urandom_range(65535)), pick_delay());
         calm = (p == 4);
         run_bursts(PHASE_ITEMS);
      end
      calm = 1'b0;

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_cnt == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
